>>> hdl/abb_pkg.sv
// Shared constants, codes and blend arithmetic for the alpha blend blitter.
package abb_pkg;

	localparam int MAX_SCREEN_WIDTH_DEF  = 512;
	localparam int MAX_SCREEN_HEIGHT_DEF = 512;

	localparam int FUNC_W     = 2;
	localparam int COORD_W    = 10;
	localparam int SRC_DIM_W  = 11;
	localparam int SCR_DIM_W  = 10;
	localparam int PIX_W      = 32;
	localparam int IDX_W      = 18;
	localparam int STATUS_W   = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 5;

	localparam logic [SRC_DIM_W-1:0] SOURCE_DIM_RST = 11'd1024;
	localparam logic [SCR_DIM_W-1:0] SCREEN_DIM_RST = 10'd512;

	localparam logic [FUNC_W-1:0] FUNC_BLEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd1;

	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CLIPPED   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SRC_RANGE = 2'd2;

	typedef enum logic [2:0] {
		REG_RECT_LEFT     = 3'd0,
		REG_RECT_TOP      = 3'd1,
		REG_DEST_X        = 3'd2,
		REG_DEST_Y        = 3'd3,
		REG_SOURCE_WIDTH  = 3'd4,
		REG_SOURCE_HEIGHT = 3'd5,
		REG_SCREEN_WIDTH  = 3'd6,
		REG_SCREEN_HEIGHT = 3'd7
	} cfg_reg_t;

	localparam logic [7:0] ALPHA_MAX = 8'd255;

	// floor(x / 255), exact for x up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [7:0] mix_chan(input logic [7:0] a, input logic [7:0] s,
			input logic [7:0] d);
		logic [15:0] acc;
		acc = 16'(a) * 16'(s) + 16'(ALPHA_MAX - a) * 16'(d);
		return div255(acc);
	endfunction

	// byte 3 = B, byte 0 = A on the way in
	function automatic logic [PIX_W-1:0] bgra_to_argb(input logic [PIX_W-1:0] c);
		return {c[7:0], c[15:8], c[23:16], c[31:24]};
	endfunction

	function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] dst,
			input logic [PIX_W-1:0] src);
		logic [7:0] sa;
		logic [7:0] fa;
		sa = src[31:24];
		fa = sa + div255(16'(dst[31:24]) * 16'(ALPHA_MAX - sa));
		return {fa, mix_chan(sa, src[23:16], dst[23:16]), mix_chan(sa, src[15:8], dst[15:8]),
			mix_chan(sa, src[7:0], dst[7:0])};
	endfunction

endpackage

>>> hdl/abb_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port (read-first).
module abb_ram #(
	parameter int WIDTH = abb_pkg::PIX_W,
	parameter int DEPTH = abb_pkg::MAX_SCREEN_WIDTH_DEF * abb_pkg::MAX_SCREEN_HEIGHT_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/alpha_blend_blitter_unit.sv
// Alpha blend blitter top level: config registers, pixel pipeline and frame store.
// A request accepted at a clock edge is registered through stages 1, 2 and 3 before its result strobe.
// Throughput: one request per clock; busy is never raised.
// Stage 1 checks clipping, stage 2 forms the store address and reads, stage 3 blends
// and writes back; a one-entry bypass of the last write covers back-to-back same-pixel.
// Reset clears the config registers to their defaults and the pipeline valids;
// the frame store is not cleared and holds garbage until written.
module alpha_blend_blitter_unit #(
	parameter int MAX_SCREEN_WIDTH  = abb_pkg::MAX_SCREEN_WIDTH_DEF,
	parameter int MAX_SCREEN_HEIGHT = abb_pkg::MAX_SCREEN_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [abb_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [abb_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [abb_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            start,
	output logic                            busy,
	input  logic [abb_pkg::FUNC_W-1:0]      func,
	input  logic [abb_pkg::COORD_W-1:0]     x_offset,
	input  logic [abb_pkg::COORD_W-1:0]     y_offset,
	input  logic [abb_pkg::PIX_W-1:0]       source_pixel,
	output logic                            done,
	output logic [abb_pkg::STATUS_W-1:0]    status,
	output logic [abb_pkg::IDX_W-1:0]       pixel_index,
	output logic [abb_pkg::PIX_W-1:0]       pixel_value
);

	import abb_pkg::*;

	localparam int DEPTH = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int SWW   = $clog2(MAX_SCREEN_WIDTH + 1);
	localparam int SHW   = $clog2(MAX_SCREEN_HEIGHT + 1);
	localparam int MW    = (SWW > SHW) ? SWW : SHW;
	localparam int DIM_W = (MW > COORD_W + 1) ? MW : COORD_W + 1;
	localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

	// configuration registers
	logic [COORD_W-1:0]   rect_left_q, rect_top_q, dest_x_q, dest_y_q;
	logic [SRC_DIM_W-1:0] source_width_q, source_height_q;
	logic [SCR_DIM_W-1:0] screen_width_q, screen_height_q;

	logic     cfg_wr;
	cfg_reg_t cfg_sel;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q     <= '0;
			rect_top_q      <= '0;
			dest_x_q        <= '0;
			dest_y_q        <= '0;
			source_width_q  <= SOURCE_DIM_RST;
			source_height_q <= SOURCE_DIM_RST;
			screen_width_q  <= SCREEN_DIM_RST;
			screen_height_q <= SCREEN_DIM_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_RECT_LEFT:     rect_left_q     <= pwdata[COORD_W-1:0];
				REG_RECT_TOP:      rect_top_q      <= pwdata[COORD_W-1:0];
				REG_DEST_X:        dest_x_q        <= pwdata[COORD_W-1:0];
				REG_DEST_Y:        dest_y_q        <= pwdata[COORD_W-1:0];
				REG_SOURCE_WIDTH:  source_width_q  <= pwdata[SRC_DIM_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= pwdata[SRC_DIM_W-1:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[SCR_DIM_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[SCR_DIM_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_RECT_LEFT:     prdata = CFG_DATA_W'(rect_left_q);
			REG_RECT_TOP:      prdata = CFG_DATA_W'(rect_top_q);
			REG_DEST_X:        prdata = CFG_DATA_W'(dest_x_q);
			REG_DEST_Y:        prdata = CFG_DATA_W'(dest_y_q);
			REG_SOURCE_WIDTH:  prdata = CFG_DATA_W'(source_width_q);
			REG_SOURCE_HEIGHT: prdata = CFG_DATA_W'(source_height_q);
			REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(screen_width_q);
			REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(screen_height_q);
		endcase
	end

	// effective screen size, saturated to the store
	logic [DIM_W-1:0] sw, sh;

	always_comb begin
		sw = (DIM_W'(screen_width_q) > DIM_W'(MAX_SCREEN_WIDTH)) ?
			DIM_W'(MAX_SCREEN_WIDTH) : DIM_W'(screen_width_q);
		sh = (DIM_W'(screen_height_q) > DIM_W'(MAX_SCREEN_HEIGHT)) ?
			DIM_W'(MAX_SCREEN_HEIGHT) : DIM_W'(screen_height_q);
	end

	// stage 1: coordinates and checks
	logic             accept;
	logic             is_blend;
	logic [DIM_W-1:0] dx, dy;

	assign accept   = start && !busy;
	assign is_blend = (func == FUNC_BLEND);

	always_comb begin
		if (is_blend) begin
			dx = DIM_W'(dest_x_q) + DIM_W'(x_offset);
			dy = DIM_W'(dest_y_q) + DIM_W'(y_offset);
		end else begin
			dx = DIM_W'(x_offset);
			dy = DIM_W'(y_offset);
		end
	end

	logic                 v_s1, clip_s1, oor_s1;
	logic [FUNC_W-1:0]    func_s1;
	logic [DIM_W-1:0]     dx_s1, dy_s1;
	logic [PIX_W-1:0]     pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			dx_s1   <= dx;
			dy_s1   <= dy;
			clip_s1 <= (dx >= sw) || (dy >= sh);
			oor_s1  <= (SRC_DIM_W'(rect_left_q) + SRC_DIM_W'(x_offset) >= source_width_q) ||
				(SRC_DIM_W'(rect_top_q) + SRC_DIM_W'(y_offset) >= source_height_q);
			pix_s1  <= source_pixel;
		end
	end

	// stage 2: linear address, store read issued here
	logic [2*DIM_W-1:0] row_base;
	logic [AW-1:0]      addr;

	assign row_base = dy_s1 * sw;
	assign addr     = AW'(row_base) + AW'(dx_s1);

	logic              v_s2, clip_s2, oor_s2;
	logic [FUNC_W-1:0] func_s2;
	logic [AW-1:0]     addr_s2;
	logic [PIX_W-1:0]  pix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			func_s2 <= func_s1;
			clip_s2 <= clip_s1;
			oor_s2  <= oor_s1;
			addr_s2 <= addr;
			pix_s2  <= pix_s1;
		end
	end

	// stage 3: bypass, blend, write back
	logic             we;
	logic [PIX_W-1:0] rdata, cur, blended, wdata;
	logic             wb_v_q;
	logic [AW-1:0]    wb_addr_q;
	logic [PIX_W-1:0] wb_data_q;

	abb_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(addr_s2),
		.wdata(wdata),
		.raddr(addr),
		.rdata(rdata)
	);

	// the write issued alongside this request's read was missed by the read-first port
	assign cur     = (wb_v_q && (wb_addr_q == addr_s2)) ? wb_data_q : rdata;
	assign blended = blend_over(cur, bgra_to_argb(pix_s2));
	assign wdata   = (func_s2 == FUNC_FILL) ? pix_s2 : blended;
	assign we      = v_s2 && !clip_s2 &&
		((func_s2 == FUNC_FILL) || ((func_s2 == FUNC_BLEND) && !oor_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_v_q <= 1'b0;
		end else begin
			wb_v_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			wb_addr_q <= addr_s2;
			wb_data_q <= wdata;
		end
	end

	logic [STATUS_W-1:0] res_status;
	logic [XW-1:0]       res_index;
	logic [PIX_W-1:0]    res_value;

	always_comb begin
		res_status = STATUS_DONE;
		res_index  = XW'(addr_s2);
		res_value  = '0;
		priority if (clip_s2) begin
			res_status = STATUS_CLIPPED;
			res_index  = '0;
		end else if (func_s2 == FUNC_BLEND) begin
			if (oor_s2) begin
				res_status = STATUS_SRC_RANGE;
			end else begin
				res_value = blended;
			end
		end else if (func_s2 == FUNC_FILL) begin
			res_value = pix_s2;
		end else begin
			res_value = cur;
		end
	end

	logic                done_s3;
	logic [STATUS_W-1:0] status_s3;
	logic [IDX_W-1:0]    index_s3;
	logic [PIX_W-1:0]    value_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			status_s3 <= res_status;
			index_s3  <= res_index[IDX_W-1:0];
			value_s3  <= res_value;
		end
	end

	assign done        = done_s3;
	assign status      = status_s3;
	assign pixel_index = index_s3;
	assign pixel_value = value_s3;

endmodule

>>> hdl/abb_checker.sv
// Port-level checks on the blitter's result stream, bound to the top level.
module abb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [abb_pkg::STATUS_W-1:0] status,
	input logic [abb_pkg::IDX_W-1:0]    pixel_index,
	input logic [abb_pkg::PIX_W-1:0]    pixel_value
);

	import abb_pkg::*;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("request gave no result three cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result strobe without a matching request");

	a_clipped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_CLIPPED) |-> (pixel_index == '0) && (pixel_value == '0))
		else $error("clipped result carries a non-zero index or value");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_SRC_RANGE) |-> (pixel_value == '0))
		else $error("out-of-range result carries a value");

endmodule

bind alpha_blend_blitter_unit abb_checker u_abb_checker (.*);
